// File: hw/rtl/dith_pkg.sv
// Shared types, constants and helper functions for the bilevel error diffusion dither.
// Used by dith_line_mem, dith_out_fifo and floyd_steinberg_bilevel_dither.
package dith_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int CONTRAST_W  = 8;
    localparam int IMG_WIDTH_W = 11;
    localparam int CMP_W       = (COL_W + 1 > IMG_WIDTH_W) ? COL_W + 1 : IMG_WIDTH_W;
    localparam int ERR_W       = 10;
    localparam int E_W         = 8;
    localparam int VAL_W       = 11;
    localparam int PROD_W      = E_W + 5;
    localparam int TDATA_W     = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = IMG_WIDTH_W;

    localparam logic [CFG_IDX_W-1:0] REG_CONTRAST    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'b1;

    localparam int THRESH = 128;
    localparam int WHITE  = 255;

    localparam logic [3:0] W_RIGHT       = 4'd7;
    localparam logic [3:0] W_BELOW_LEFT  = 4'd3;
    localparam logic [3:0] W_BELOW       = 4'd5;
    localparam logic [3:0] W_BELOW_RIGHT = 4'd1;

    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef logic [COL_W-1:0]        col_t;
    typedef logic signed [ERR_W-1:0] err_t;
    typedef logic signed [E_W-1:0]   qerr_t;

    typedef struct packed {
        logic we;
        col_t addr;
        err_t data;
    } mem_wr_t;

    typedef struct packed {
        logic pixel_out;
        logic row_end;
    } res_t;

    // weight * e / 16, truncated toward zero
    function automatic qerr_t share(input qerr_t e, input logic [3:0] weight);
        logic signed [PROD_W-1:0] p;
        logic signed [PROD_W-1:0] q;
        logic signed [PROD_W-1:0] r;
        p = PROD_W'(e) * $signed({{(PROD_W - 4){1'b0}}, weight});
        q = p[PROD_W-1] ? p + PROD_W'(15) : p;
        r = q >>> 4;
        share = r[E_W-1:0];
    endfunction

endpackage

// File: hw/rtl/dith_line_mem.sv
// Line buffer holding the diffused error for the row below, one entry per column.
// One write port, one read port, read data registered. Depends on dith_pkg.
module dith_line_mem
    import dith_pkg::*;
(
    input  logic    aclk,
    input  mem_wr_t wr,
    input  col_t    rd_addr,
    output err_t    rd_data
);

    err_t mem_array [MAX_WIDTH];
    err_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem_array[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem_array[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/dith_out_fifo.sv
// Small result queue driving the master stream port.
// Decouples the compute stage from output backpressure. Depends on dith_pkg.
module dith_out_fifo
    import dith_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  res_t                  push_data,
    output logic [FIFO_CNT_W-1:0] count,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,   // [0] pixel_out, [7:1] zero
    output logic                  m_tlast    // row_end
);

    res_t                  entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_next;
    logic                  pop;
    res_t                  head;

    assign pop  = m_tvalid && m_tready;
    assign head = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10: count_next = count_reg + 1'b1;
            2'b01: count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign count    = count_reg;
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {{(TDATA_W - 1){1'b0}}, head.pixel_out};
    assign m_tlast  = head.row_end;

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg != FIFO_CNT_W'(FIFO_DEPTH)) || pop)
        else $error("result queue overflow");

endmodule

// File: hw/rtl/floyd_steinberg_bilevel_dither.sv
// Bilevel Floyd-Steinberg error diffusion: one request in, one dithered pixel out.
// Accepted requests are registered in the compute stage, then queued in the output FIFO.
// Throughput: one pixel per cycle while the output queue has room, limited by the single
// write port of the line buffer. Reset: synchronous, active low; afterwards the 1024-entry
// line buffer is zeroed, one entry per cycle, with s_tready low.
// Config writes are taken always. Depends on dith_pkg, dith_line_mem and dith_out_fifo.
module floyd_steinberg_bilevel_dither
    import dith_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,   // [0] pixel_in, [7:1] unused
    input  logic                  s_tuser,   // frame_start
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,   // [0] pixel_out, [7:1] zero
    output logic                  m_tlast    // row_end
);

    logic [CONTRAST_W-1:0]  contrast_reg;
    logic [IMG_WIDTH_W-1:0] image_width_reg;

    logic clr_busy_reg;
    col_t clr_addr_reg;

    col_t column_reg;
    logic first_row_reg;

    logic s1_valid_reg;
    logic s1_pixel_reg;
    logic s1_fs_reg;
    logic s1_first_reg;
    logic s1_last_reg;
    col_t s1_col_reg;

    qerr_t carry_reg;
    err_t  pbl_reg;
    err_t  pb_reg;

    logic defer_valid_reg;
    col_t defer_addr_reg;
    err_t defer_data_reg;

    logic bypass_hit_reg;
    err_t bypass_data_reg;

    logic                  accept;
    logic [CMP_W-1:0]      width_ext;
    logic [CMP_W-1:0]      w_eff;
    col_t                  col_eff;
    logic                  first_eff;
    logic                  last0;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [FIFO_CNT_W:0]   occupancy;

    mem_wr_t wr;
    err_t    rd_data;

    qerr_t                 carry_use;
    err_t                  pbl_use;
    err_t                  pb_use;
    logic [CONTRAST_W-1:0] base;
    err_t                  above_mem;
    err_t                  above;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] diff;
    logic                  black;
    qerr_t                 e;
    qerr_t                 s7;
    qerr_t                 s3;
    qerr_t                 s5;
    qerr_t                 s1;
    err_t                  left_data;
    err_t                  below_sum;
    res_t                  result;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            contrast_reg    <= '0;
            image_width_reg <= IMG_WIDTH_W'(MAX_WIDTH);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_CONTRAST:    contrast_reg    <= cfg_data[CONTRAST_W-1:0];
                REG_IMAGE_WIDTH: image_width_reg <= cfg_data[IMG_WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- accept stage: column tracking, buffer read ----------------
    assign occupancy = {1'b0, fifo_count} + (FIFO_CNT_W + 1)'(s1_valid_reg);
    assign s_tready  = !clr_busy_reg && (occupancy < (FIFO_CNT_W + 1)'(FIFO_DEPTH));
    assign accept    = s_tvalid && s_tready;

    assign width_ext = CMP_W'(image_width_reg);
    assign w_eff     = (width_ext == '0) ? CMP_W'(1) :
                       (width_ext > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : width_ext;
    assign col_eff   = s_tuser ? '0 : column_reg;
    assign first_eff = s_tuser || first_row_reg;
    assign last0     = (CMP_W'(col_eff) + CMP_W'(1)) >= w_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg    <= '0;
            first_row_reg <= 1'b1;
            s1_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
            if (accept) begin
                column_reg    <= last0 ? '0 : col_eff + 1'b1;
                first_row_reg <= last0 ? 1'b0 : first_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pixel_reg <= s_tdata[0];
            s1_fs_reg    <= s_tuser;
            s1_first_reg <= first_eff;
            s1_last_reg  <= last0;
            s1_col_reg   <= col_eff;
        end
        bypass_hit_reg  <= wr.we && (wr.addr == col_eff);
        bypass_data_reg <= wr.data;
    end

    // ---------------- compute stage ----------------
    assign carry_use = s1_fs_reg ? '0 : carry_reg;
    assign pbl_use   = s1_fs_reg ? '0 : pbl_reg;
    assign pb_use    = s1_fs_reg ? '0 : pb_reg;

    assign above_mem = (defer_valid_reg && (defer_addr_reg == s1_col_reg)) ? defer_data_reg :
                       bypass_hit_reg ? bypass_data_reg : rd_data;
    assign above     = s1_first_reg ? '0 : above_mem;

    assign base  = s1_pixel_reg ? (CONTRAST_W'(WHITE) - contrast_reg) : CONTRAST_W'(WHITE);
    assign value = $signed({{(VAL_W - CONTRAST_W){1'b0}}, base}) + VAL_W'(carry_use)
                   + VAL_W'(above);
    assign black = value < VAL_W'(THRESH);
    assign diff  = black ? value : value - VAL_W'(WHITE);
    assign e     = diff[E_W-1:0];

    assign s7 = share(e, W_RIGHT);
    assign s3 = share(e, W_BELOW_LEFT);
    assign s5 = share(e, W_BELOW);
    assign s1 = share(e, W_BELOW_RIGHT);

    assign left_data = pbl_use + ERR_W'(s3);
    assign below_sum = pb_use + ERR_W'(s5);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carry_reg       <= '0;
            pbl_reg         <= '0;
            pb_reg          <= '0;
            defer_valid_reg <= 1'b0;
        end else begin
            defer_valid_reg <= s1_valid_reg && s1_last_reg;
            if (s1_valid_reg) begin
                carry_reg <= s1_last_reg ? '0 : s7;
                pbl_reg   <= s1_last_reg ? '0 : below_sum;
                pb_reg    <= s1_last_reg ? '0 : ERR_W'(s1);
            end
        end
    end

    // hold the end-of-row entry in a register; the next pixel starts a row and writes nothing
    always_ff @(posedge aclk) begin
        if (s1_valid_reg && s1_last_reg) begin
            defer_addr_reg <= s1_col_reg;
            defer_data_reg <= below_sum;
        end
    end

    // ---------------- line buffer write port and clearing sweep ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == COL_W'(MAX_WIDTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        priority if (clr_busy_reg) begin
            wr.we   = 1'b1;
            wr.addr = clr_addr_reg;
            wr.data = '0;
        end else if (s1_valid_reg && (s1_col_reg != '0)) begin
            wr.we   = 1'b1;
            wr.addr = s1_col_reg - 1'b1;
            wr.data = left_data;
        end else if (defer_valid_reg) begin
            wr.we   = 1'b1;
            wr.addr = defer_addr_reg;
            wr.data = defer_data_reg;
        end else begin
            wr.we   = 1'b0;
            wr.addr = defer_addr_reg;
            wr.data = defer_data_reg;
        end
    end

    dith_line_mem u_line_mem (
        .aclk    (aclk),
        .wr      (wr),
        .rd_addr (col_eff),
        .rd_data (rd_data)
    );

    // ---------------- output ----------------
    assign result.pixel_out = black;
    assign result.row_end   = s1_last_reg;

    dith_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s1_valid_reg),
        .push_data (result),
        .count     (fifo_count),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    a_defer_port_free: assert property (@(posedge aclk) disable iff (!aresetn)
        defer_valid_reg |-> !(s1_valid_reg && (s1_col_reg != '0)))
        else $error("deferred row-end write collides with left write");

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !s_tready)
        else $error("request accepted during line buffer clear");

    a_stage_follows_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> $past(s_tvalid && s_tready))
        else $error("compute stage valid without accepted request");

endmodule

// File: dv/floyd_steinberg_bilevel_dither_test.sv
// Self-checking testbench for floyd_steinberg_bilevel_dither: directed plan, then random frames.
// Predicts each pixel in-house or takes typed plan rows' values; checks both stream fields in order.
// Depends on dith_pkg and the floyd_steinberg_bilevel_dither RTL.
module floyd_steinberg_bilevel_dither_test;
    import dith_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1600;
    localparam int WIDE_AFTER   = 0;
    localparam int SETTLE       = 4;
    localparam int DRAIN        = 8;
    localparam int IDLE_LIMIT   = 6000;
    localparam int PLAN_LEN     = 36;

    typedef enum logic {ROW_PIX, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic                  pixel;
        logic                  frame;
        logic                  typed;
        logic                  want_pix;
        logic                  want_end;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
    } plan_row_t;

    plan_row_t plan [PLAN_LEN] = '{
        '{ROW_PIX, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, REG_CONTRAST, 11'd0},
        '{ROW_PIX, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, REG_CONTRAST, 11'd0},
        '{ROW_CFG, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, REG_CONTRAST, 11'd255},
        '{ROW_CFG, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, REG_IMAGE_WIDTH, 11'd1},
        '{ROW_PIX, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, REG_CONTRAST, 11'd0},
        '{ROW_PIX, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, REG_CONTRAST, 11'd0},
        '{ROW_CFG, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, REG_IMAGE_WIDTH, 11'd0},
        '{ROW_PIX, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, REG_CONTRAST, 11'd0},
        '{ROW_CFG, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, REG_IMAGE_WIDTH, 11'd2047},
        '{ROW_CFG, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, REG_CONTRAST, 11'd128},
        '{ROW_PIX, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, REG_CONTRAST, 11'd0},
        '{ROW_PIX, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, REG_CONTRAST, 11'd0},
        '{ROW_PIX, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, REG_CONTRAST, 11'd0},
        '{ROW_PIX, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, REG_CONTRAST, 11'd0},
        '{ROW_CFG, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, REG_IMAGE_WIDTH, 11'd3},
        '{ROW_PIX, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, REG_CONTRAST, 11'd0},
        '{ROW_PIX, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, REG_CONTRAST, 11'd0},
        '{ROW_PIX, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, REG_CONTRAST, 11'd0},
        '{ROW_PIX, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, REG_CONTRAST, 11'd0},
        '{ROW_CFG, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, REG_CONTRAST, 11'd200},
        '{ROW_PIX, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, REG_CONTRAST, 11'd0},
        '{ROW_PIX, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, REG_CONTRAST, 11'd0},
        '{ROW_PIX, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, REG_CONTRAST, 11'd0},
        '{ROW_PIX, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, REG_CONTRAST, 11'd0},
        '{ROW_PIX, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, REG_CONTRAST, 11'd0},
        '{ROW_PIX, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, REG_CONTRAST, 11'd0},
        '{ROW_CFG, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, REG_CONTRAST, 11'd100},
        '{ROW_CFG, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, REG_IMAGE_WIDTH, 11'd1025},
        '{ROW_PIX, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, REG_CONTRAST, 11'd0},
        '{ROW_PIX, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, REG_CONTRAST, 11'd0},
        '{ROW_PIX, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, REG_CONTRAST, 11'd0},
        '{ROW_CFG, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, REG_IMAGE_WIDTH, 11'd2},
        '{ROW_PIX, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, REG_CONTRAST, 11'd0},
        '{ROW_PIX, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, REG_CONTRAST, 11'd0},
        '{ROW_PIX, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, REG_CONTRAST, 11'd0},
        '{ROW_PIX, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, REG_CONTRAST, 11'd0}
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata   = '0;   // [0] pixel_in, [7:1] zero
    logic                  s_tuser   = 1'b0; // frame_start
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;          // [0] pixel_out, [7:1] zero
    logic                  m_tlast;          // row_end

    floyd_steinberg_bilevel_dither dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    // predictor state
    logic [CONTRAST_W-1:0]  contrast_r = '0;
    logic [IMG_WIDTH_W-1:0] width_r    = IMG_WIDTH_W'(MAX_WIDTH);
    err_t line_err [MAX_WIDTH];
    int   col            = 0;
    bit   top_row        = 1'b1;
    int   carry_right    = 0;
    int   acc_below_left = 0;
    int   acc_below      = 0;

    res_t dithered_q [$];
    int   mismatches = 0;
    int   quiet      = 0;
    bit   calm       = 1'b0;

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic int active_width();
        int w;
        w = width_r;
        if (w < 1)
            w = 1;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int portion(input int e, input int weight);
        return (weight * e) / 16;
    endfunction

    function automatic res_t dither_pixel(input logic pix, input logic fs);
        int   w;
        int   sum;
        int   q;
        int   e;
        bit   eol;
        res_t r;
        w = active_width();
        if (fs) begin
            col            = 0;
            top_row        = 1'b1;
            carry_right    = 0;
            acc_below_left = 0;
            acc_below      = 0;
        end
        if (col >= MAX_WIDTH)
            col = 0;
        sum = (pix ? WHITE - int'(contrast_r) : WHITE) + carry_right;
        if (!top_row)
            sum += int'(line_err[col]);
        q   = (sum < THRESH) ? 0 : WHITE;
        e   = sum - q;
        eol = (col + 1 >= w);
        if (col > 0)
            line_err[col-1] = err_t'(acc_below_left + portion(e, W_BELOW_LEFT));
        if (eol) begin
            line_err[col]  = err_t'(acc_below + portion(e, W_BELOW));
            carry_right    = 0;
            acc_below_left = 0;
            acc_below      = 0;
        end else begin
            acc_below_left = acc_below + portion(e, W_BELOW);
            acc_below      = portion(e, W_BELOW_RIGHT);
            carry_right    = portion(e, W_RIGHT);
        end
        r.pixel_out = (q == 0);
        r.row_end   = eol;
        if (eol) begin
            col     = 0;
            top_row = 1'b0;
        end else begin
            col++;
        end
        return r;
    endfunction

    task automatic send_pixel(input logic pix, input logic fs, input logic typed,
                              input res_t typed_res);
        int   gap;
        res_t r;
        gap = draw_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(pix);
        s_tuser  <= fs;
        do @(posedge aclk); while (!s_tready);
        r = dither_pixel(pix, fs);
        dithered_q.push_back(typed ? typed_res : r);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        s_tvalid <= 1'b0;
        while (dithered_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_CONTRAST)
            contrast_r = val[CONTRAST_W-1:0];
        else
            width_r = val;
    endtask

    initial begin
        res_t                  want;
        logic [CFG_DATA_W-1:0] wv;
        int                    done_items;
        int                    span;
        int                    dens;
        int                    w_eff;
        bit                    wide_done;
        logic                  fs;
        done_items = 0;
        wide_done  = 1'b0;
        for (int i = 0; i < MAX_WIDTH; i++)
            line_err[i] = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < PLAN_LEN; i++) begin
            if (plan[i].kind == ROW_CFG) begin
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                want.pixel_out = plan[i].want_pix;
                want.row_end   = plan[i].want_end;
                send_pixel(plan[i].pixel, plan[i].frame, plan[i].typed, want);
            end
        end

        want = '0;
        while (done_items < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1) != 0) begin
                case ($urandom_range(0, 3))
                    0: wv = 11'd0;
                    1: wv = 11'd255;
                    default: wv = CFG_DATA_W'($urandom_range(0, 255));
                endcase
                wv = CFG_DATA_W'($urandom_range(0, 7) * 256 + int'(wv[7:0]));
                write_reg(REG_CONTRAST, wv);
            end
            if (!wide_done && done_items >= WIDE_AFTER) begin
                wide_done = 1'b1;
                case ($urandom_range(0, 2))
                    0: wv = CFG_DATA_W'(MAX_WIDTH);
                    1: wv = 11'd2047;
                    default: wv = CFG_DATA_W'($urandom_range(MAX_WIDTH + 1, 2047));
                endcase
                write_reg(REG_IMAGE_WIDTH, wv);
                span = MAX_WIDTH + $urandom_range(16, 64);
            end else begin
                if (active_width() > 64 || $urandom_range(0, 3) != 0) begin
                    case ($urandom_range(0, 19))
                        0: wv = 11'd0;
                        1: wv = 11'd1;
                        2: wv = CFG_DATA_W'($urandom_range(13, 64));
                        default: wv = CFG_DATA_W'($urandom_range(1, 12));
                    endcase
                    write_reg(REG_IMAGE_WIDTH, wv);
                end
                w_eff = active_width();
                span  = w_eff * $urandom_range(2, 10) + $urandom_range(0, w_eff - 1);
                if (span > RANDOM_ITEMS - done_items)
                    span = RANDOM_ITEMS - done_items;
            end
            dens = $urandom_range(0, 100);
            for (int k = 0; k < span; k++) begin
                if (k == 0)
                    fs = ($urandom_range(0, 3) != 0);
                else
                    fs = ($urandom_range(0, 59) == 0);
                send_pixel($urandom_range(0, 99) < dens, fs, 1'b0, want);
            end
            done_items += span;
        end

        s_tvalid <= 1'b0;
        while (dithered_q.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (mismatches == 0)
            $display("** floyd_steinberg_bilevel_dither: PASSED **");
        else
            $display("** floyd_steinberg_bilevel_dither: FAILED **");
        $finish;
    end

    initial begin
        int gap;
        wait (aresetn === 1'b1);
        forever begin
            gap = draw_gap();
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (dithered_q.size() == 0) begin
                $error("result with none expected: pixel_out %0b row_end %0b",
                       m_tdata[0], m_tlast);
                mismatches++;
            end else begin
                want = dithered_q.pop_front();
                if (m_tdata[0] !== want.pixel_out) begin
                    $error("pixel_out: expected %0b, got %0b", want.pixel_out, m_tdata[0]);
                    mismatches++;
                end
                if (m_tlast !== want.row_end) begin
                    $error("row_end: expected %0b, got %0b", want.row_end, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= IDLE_LIMIT) begin
            $display("** floyd_steinberg_bilevel_dither: FAILED **");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

endmodule
